FILE: rtl/scfp_pkg.sv
// Shared types and constants for the sum-checked frame parser.
// No dependencies; imported by scfp_parser and sum_checked_frame_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

package scfp_pkg;

    // Frame framing constants.
    localparam logic [7:0] HDR_BYTE     = 8'hAA;
    localparam logic [7:0] FUNC_BOUND   = 8'hF1;
    localparam logic [7:0] FUNC_COMMAND = 8'h01;
    localparam logic [7:0] FUNC_MOTION  = 8'h02;
    localparam logic [7:0] LIMIT_RESET  = 8'd50;

    // Codes reported in update_kind.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_MOTION  = 2'd2;

    // Configuration register word index.
    localparam logic REG_LENGTH_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_FUNC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_SUM   = 3'd5
    } phase_t;

    typedef struct packed {
        logic               frame_ok;
        logic [7:0]         function_code;
        logic [1:0]         update_kind;
        logic [7:0]         command_value;
        logic signed [15:0] speed_value;
        logic signed [15:0] direction_value;
    } scfp_result_t;

endpackage

`default_nettype wire

FILE: rtl/scfp_parser.sv
// Frame parser core: phase state machine, running sum, payload slots and held values.
// Depends on scfp_pkg; instantiated by sum_checked_frame_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

module scfp_parser
    import scfp_pkg::*;
#(
    parameter int STORED_SLOTS = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step,
    input  wire logic [7:0]   rx_byte,
    input  wire logic [7:0]   length_limit,
    output logic              emit,
    output scfp_result_t      result
);

    localparam int         SLOT_W  = $clog2(STORED_SLOTS);
    localparam logic [7:0] SLOTS_B = 8'(STORED_SLOTS);

    phase_t              phase_reg, phase_next;
    logic [7:0]          bytes_left_reg, bytes_left_next;
    logic [7:0]          bytes_taken_reg, bytes_taken_next;
    logic [7:0]          running_sum_reg, running_sum_next;
    logic [7:0]          held_function_reg, held_function_next;
    logic [7:0]          slot_reg [STORED_SLOTS];
    logic [7:0]          slot_view [STORED_SLOTS];
    logic [7:0]          held_command_reg, held_command_next;
    logic [15:0]         held_speed_reg, held_speed_next;
    logic [15:0]         held_direction_reg, held_direction_next;
    logic                slot_wr;
    logic [SLOT_W-1:0]   slot_idx;
    logic                sum_match;
    logic [1:0]          kind;

    // Next phase.
    always_comb begin
        phase_next = PH_HUNT1;
        unique case (phase_reg)
            PH_HUNT1: phase_next = (rx_byte == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
            PH_HUNT2: phase_next = (rx_byte == HDR_BYTE) ? PH_FUNC : PH_HUNT1;
            PH_FUNC:  phase_next = (rx_byte < FUNC_BOUND) ? PH_LEN : PH_HUNT1;
            PH_LEN:   phase_next = (rx_byte < length_limit) ? PH_DATA : PH_HUNT1;
            PH_DATA: begin
                if (bytes_left_reg == 8'd0) begin
                    phase_next = PH_HUNT1;
                end else if (bytes_left_reg == 8'd1) begin
                    phase_next = PH_SUM;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_SUM:   phase_next = PH_HUNT1;
            default:  phase_next = PH_HUNT1;
        endcase
    end

    // Slot writes happen on payload bytes and on the sum byte, within the stored range.
    assign slot_idx  = bytes_taken_reg[SLOT_W-1:0];
    assign sum_match = (running_sum_reg == rx_byte);

    always_comb begin
        slot_wr = 1'b0;
        if (bytes_taken_reg < SLOTS_B) begin
            slot_wr = ((phase_reg == PH_DATA) && (bytes_left_reg != 8'd0))
                   || (phase_reg == PH_SUM);
        end
    end

    // The sum byte may land in a slot that the motion update reads in the same cycle.
    always_comb begin
        for (int i = 0; i < STORED_SLOTS; i++) begin
            slot_view[i] = (slot_wr && (slot_idx == SLOT_W'(i))) ? rx_byte : slot_reg[i];
        end
    end

    // Datapath updates for each phase.
    always_comb begin
        bytes_left_next     = bytes_left_reg;
        bytes_taken_next    = bytes_taken_reg;
        running_sum_next    = running_sum_reg;
        held_function_next  = held_function_reg;
        held_command_next   = held_command_reg;
        held_speed_next     = held_speed_reg;
        held_direction_next = held_direction_reg;
        kind                = KIND_NONE;
        emit                = 1'b0;
        unique case (phase_reg)
            PH_HUNT1: begin
                running_sum_next = rx_byte;
            end
            PH_HUNT2, PH_FUNC: begin
                running_sum_next   = running_sum_reg + rx_byte;
                held_function_next = (phase_reg == PH_FUNC) ? rx_byte : held_function_reg;
            end
            PH_LEN: begin
                bytes_left_next  = rx_byte;
                bytes_taken_next = 8'd0;
                running_sum_next = running_sum_reg + rx_byte;
            end
            PH_DATA: begin
                if (bytes_left_reg != 8'd0) begin
                    bytes_left_next  = bytes_left_reg - 8'd1;
                    bytes_taken_next = bytes_taken_reg + 8'd1;
                    running_sum_next = running_sum_reg + rx_byte;
                end
            end
            PH_SUM: begin
                emit = 1'b1;
                if (sum_match && (held_function_reg == FUNC_COMMAND)) begin
                    held_command_next = slot_view[0];
                    kind              = KIND_COMMAND;
                end else if (sum_match && (held_function_reg == FUNC_MOTION)) begin
                    held_speed_next     = {slot_view[0], slot_view[1]};
                    held_direction_next = {slot_view[2], slot_view[3]};
                    kind                = KIND_MOTION;
                end
            end
            default: begin
            end
        endcase
    end

    // Rejected bytes change only the phase, so the datapath registers load
    // only when the byte was taken as part of a frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HUNT1;
            bytes_left_reg     <= 8'd0;
            bytes_taken_reg    <= 8'd0;
            running_sum_reg    <= 8'd0;
            held_function_reg  <= 8'd0;
            held_command_reg   <= 8'd0;
            held_speed_reg     <= 16'd0;
            held_direction_reg <= 16'd0;
            for (int i = 0; i < STORED_SLOTS; i++) begin
                slot_reg[i] <= 8'd0;
            end
        end else if (step) begin
            phase_reg <= phase_next;
            if ((phase_next != PH_HUNT1) || (phase_reg == PH_SUM)) begin
                bytes_left_reg     <= bytes_left_next;
                bytes_taken_reg    <= bytes_taken_next;
                running_sum_reg    <= running_sum_next;
                held_function_reg  <= held_function_next;
                held_command_reg   <= held_command_next;
                held_speed_reg     <= held_speed_next;
                held_direction_reg <= held_direction_next;
            end
            if (slot_wr) begin
                slot_reg[slot_idx] <= rx_byte;
            end
        end
    end

    always_comb begin
        result.frame_ok        = sum_match;
        result.function_code   = held_function_reg;
        result.update_kind     = kind;
        result.command_value   = held_command_next;
        result.speed_value     = held_speed_next;
        result.direction_value = held_direction_next;
    end

    a_sum_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        step && emit |=> phase_reg == PH_HUNT1)
        else $error("parser did not return to hunting after a sum byte");

    a_sum_phase_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SUM |-> (bytes_left_reg == 8'd0) && (bytes_taken_reg != 8'd0))
        else $error("sum phase reached with payload counts out of step");

    // An empty payload count in the payload phase only follows a zero length byte.
    a_data_zero_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) && (bytes_left_reg == 8'd0) |-> bytes_taken_reg == 8'd0)
        else $error("payload phase ran out of bytes without reaching the sum byte");

endmodule

`default_nettype wire

FILE: rtl/sum_checked_frame_parser_unit.sv
// Top level of the sum-checked frame parser: input register, parser core,
// result register and APB configuration port. Depends on scfp_pkg and scfp_parser.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_rx_byte (one received byte)
//  m_        out        m_valid/m_ready    frame_ok, function_code, update_kind,
//                                          command_value, speed_value, direction_value
//  APB       in         psel/penable       length_limit at address 0
//
// One byte is accepted per cycle while s_ready is high. The parser step between the
// input and result registers computes a result as its sum byte leaves the input
// register. Reset is synchronous: length_limit returns to 50 and all parser state
// to zero. While m_ready is low with a result held, one more byte is buffered
// and then s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_parser_unit
    import scfp_pkg::*;
#(
    parameter int STORED_SLOTS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_frame_ok,
    output logic [7:0]              m_function_code,
    output logic [1:0]              m_update_kind,
    output logic [7:0]              m_command_value,
    output logic signed [15:0]      m_speed_value,
    output logic signed [15:0]      m_direction_value,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic          in_vld_reg, in_vld_next;
    logic [7:0]    in_byte_reg;
    logic          out_vld_reg, out_vld_next;
    scfp_result_t  out_res_reg;
    logic [7:0]    length_limit_reg;
    logic          consume;
    logic          emit;
    scfp_result_t  step_result;

    // A buffered byte moves through the parser when the result register can take a result.
    assign consume = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || consume;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (consume) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (consume && emit) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    scfp_parser #(
        .STORED_SLOTS (STORED_SLOTS)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (consume),
        .rx_byte      (in_byte_reg),
        .length_limit (length_limit_reg),
        .emit         (emit),
        .result       (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            length_limit_reg <= LIMIT_RESET;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH_LIMIT)) begin
                length_limit_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (consume && emit) begin
            out_res_reg <= step_result;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LENGTH_LIMIT) ? {24'd0, length_limit_reg} : 32'd0;

    assign m_valid           = out_vld_reg;
    assign m_frame_ok        = out_res_reg.frame_ok;
    assign m_function_code   = out_res_reg.function_code;
    assign m_update_kind     = out_res_reg.update_kind;
    assign m_command_value   = out_res_reg.command_value;
    assign m_speed_value     = out_res_reg.speed_value;
    assign m_direction_value = out_res_reg.direction_value;

    a_update_needs_good_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_update_kind == KIND_NONE) || m_frame_ok)
        else $error("stored update reported on a frame with a bad sum");

    a_motion_function: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_update_kind == KIND_MOTION) |-> m_function_code == FUNC_MOTION)
        else $error("motion update reported for another function code");

    a_command_function: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_update_kind == KIND_COMMAND) |-> m_function_code == FUNC_COMMAND)
        else $error("command update reported for another function code");

    a_buffer_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !consume |=> in_vld_reg && $stable(in_byte_reg))
        else $error("buffered byte lost while the result side stalled");

endmodule

`default_nettype wire

FILE: verif/sum_checked_frame_parser_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sum_checked_frame_parser_unit. A scoreboard class parses
// the accepted byte stream on its own and checks every frame result in order.
// Depends on scfp_pkg and the parser RTL; reads no files.

module sum_checked_frame_parser_unit_test;
    import scfp_pkg::*;

    localparam int SLOT_COUNT     = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam logic [2:0] LIMIT_ADDR = {REG_LENGTH_LIMIT, 2'b00};

    class frame_result_tracker;
        logic [7:0]         limit_now;
        phase_t             parse_phase;
        logic [7:0]         bytes_left;
        logic [7:0]         bytes_taken;
        logic [7:0]         running_sum;
        logic [7:0]         frame_function;
        logic [7:0]         slots [SLOT_COUNT];
        logic [7:0]         command_now;
        logic signed [15:0] speed_now;
        logic signed [15:0] direction_now;
        scfp_result_t       awaited_frames [$];
        int                 errors;

        function new();
            limit_now      = LIMIT_RESET;
            parse_phase    = PH_HUNT1;
            bytes_left     = 8'h00;
            bytes_taken    = 8'h00;
            running_sum    = 8'h00;
            frame_function = 8'h00;
            command_now    = 8'h00;
            speed_now      = 16'sh0000;
            direction_now  = 16'sh0000;
            foreach (slots[i]) slots[i] = 8'h00;
            errors = 0;
        endfunction

        // Payload positions past the stored slots only enter the sum.
        function void store_slot(logic [7:0] b);
            if (bytes_taken < SLOT_COUNT) slots[int'(bytes_taken)] = b;
        endfunction

        function void parse_byte(logic [7:0] b);
            scfp_result_t r;
            if (parse_phase == PH_HUNT1 && b == HDR_BYTE) begin
                parse_phase = PH_HUNT2;
                running_sum = b;
            end else if (parse_phase == PH_HUNT2 && b == HDR_BYTE) begin
                parse_phase = PH_FUNC;
                running_sum += b;
            end else if (parse_phase == PH_FUNC && b < FUNC_BOUND) begin
                parse_phase = PH_LEN;
                frame_function = b;
                running_sum += b;
            end else if (parse_phase == PH_LEN && b < limit_now) begin
                parse_phase = PH_DATA;
                bytes_left = b;
                bytes_taken = 8'h00;
                running_sum += b;
            end else if (parse_phase == PH_DATA && bytes_left != 0) begin
                store_slot(b);
                bytes_taken++;
                bytes_left--;
                running_sum += b;
                if (bytes_left == 0) parse_phase = PH_SUM;
            end else if (parse_phase == PH_SUM) begin
                parse_phase = PH_HUNT1;
                store_slot(b);
                r.frame_ok = (running_sum == b);
                r.update_kind = KIND_NONE;
                if (r.frame_ok) begin
                    if (frame_function == FUNC_COMMAND) begin
                        command_now = slots[0];
                        r.update_kind = KIND_COMMAND;
                    end else if (frame_function == FUNC_MOTION) begin
                        speed_now = {slots[0], slots[1]};
                        direction_now = {slots[2], slots[3]};
                        r.update_kind = KIND_MOTION;
                    end
                end
                r.function_code   = frame_function;
                r.command_value   = command_now;
                r.speed_value     = speed_now;
                r.direction_value = direction_now;
                awaited_frames.push_back(r);
            end else begin
                // A byte that does not fit is dropped, even a header byte.
                parse_phase = PH_HUNT1;
            end
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(scfp_result_t got);
            scfp_result_t want;
            if (awaited_frames.size() == 0) begin
                $error("result with no frame pending: frame_ok %0d, function_code %0d",
                       got.frame_ok, got.function_code);
                errors++;
                return;
            end
            want = awaited_frames.pop_front();
            compare_field("frame_ok", want.frame_ok, got.frame_ok);
            compare_field("function_code", want.function_code, got.function_code);
            compare_field("update_kind", want.update_kind, got.update_kind);
            compare_field("command_value", want.command_value, got.command_value);
            compare_field("speed_value", longint'($signed(want.speed_value)),
                          longint'($signed(got.speed_value)));
            compare_field("direction_value", longint'($signed(want.direction_value)),
                          longint'($signed(got.direction_value)));
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_ready   = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = 3'd0;
    logic [31:0]        pwdata    = 32'h0;
    logic               s_ready;
    logic               m_valid;
    logic               m_frame_ok;
    logic [7:0]         m_function_code;
    logic [1:0]         m_update_kind;
    logic [7:0]         m_command_value;
    logic signed [15:0] m_speed_value;
    logic signed [15:0] m_direction_value;
    logic [31:0]        prdata;
    logic               pready;

    frame_result_tracker tracker;
    logic [7:0]          frame_stream [$];
    bit                  tx_calm   = 1'b0;
    bit                  rx_calm   = 1'b0;
    logic                want_hold = 1'b0;
    bit                  hold_done = 1'b0;
    int                  hold_left = 0;
    int                  ready_gap = 0;
    int                  quiet_cycles = 0;

    sum_checked_frame_parser_unit #(
        .STORED_SLOTS(SLOT_COUNT)
    ) dut (.*);

    always #5 aclk = ~aclk;

    // Queues one frame; the first four payload bytes come from head, big-endian.
    function automatic void push_framed(logic [7:0] fn, logic [7:0] len, logic [31:0] head,
                                        bit corrupt);
        logic [7:0] total;
        logic [7:0] b;
        total = HDR_BYTE + HDR_BYTE + fn + len;
        frame_stream.push_back(HDR_BYTE);
        frame_stream.push_back(HDR_BYTE);
        frame_stream.push_back(fn);
        frame_stream.push_back(len);
        for (int i = 0; i < len; i++) begin
            b = (i < 4) ? head[31 - 8 * i -: 8] : 8'($urandom);
            frame_stream.push_back(b);
            total += b;
        end
        if (corrupt) total += 8'($urandom_range(1, 255));
        frame_stream.push_back(total);
    endfunction

    function automatic void push_random_traffic(logic [7:0] lim);
        int         pick;
        logic [7:0] fn;
        logic [7:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 4))
                frame_stream.push_back(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom));
        end else if (pick < 14) begin
            // A header followed by a function or a length that breaks the frame.
            frame_stream.push_back(HDR_BYTE);
            frame_stream.push_back(HDR_BYTE);
            if ($urandom_range(0, 1) == 0 || lim == 0) begin
                frame_stream.push_back(8'($urandom_range(FUNC_BOUND, 255)));
            end else begin
                frame_stream.push_back(8'($urandom_range(0, FUNC_BOUND - 1)));
                frame_stream.push_back(8'($urandom_range(lim, 255)));
            end
        end else begin
            pick = $urandom_range(0, 99);
            fn = (pick < 35) ? FUNC_COMMAND :
                 (pick < 70) ? FUNC_MOTION : 8'($urandom_range(0, FUNC_BOUND - 1));
            pick = $urandom_range(0, 99);
            if (lim <= 1)
                len = (pick < 50) ? 8'h00 : 8'($urandom_range(0, 6));
            else if (pick < 10)
                len = 8'h00;
            else if (pick < 13)
                len = 8'($urandom_range(1, lim - 1));
            else
                len = 8'($urandom_range(1, (lim > 7) ? 6 : lim - 1));
            push_framed(fn, len, $urandom, $urandom_range(0, 99) < 15);
        end
    endfunction

    task automatic send_stream();
        int         gap;
        logic [7:0] b;
        while (frame_stream.size() != 0) begin
            b = frame_stream.pop_front();
            if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
            gap = tx_calm ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_rx_byte <= b;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            tracker.parse_byte(b);
        end
        s_valid <= 1'b0;
    endtask

    // Bytes that cause no result may still be in flight after the last result.
    task automatic wait_drained();
        while (tracker.awaited_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_limit(logic [7:0] lim);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= {24'($urandom), lim};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.limit_now = lim;
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback[7:0] !== lim) begin
            $error("length_limit: expected %0d, got %0d", lim, readback[7:0]);
            tracker.errors++;
        end
    endtask

    always @(posedge aclk) begin : receiver
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_gap <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (want_hold && !hold_done) begin
            // One long stall so the result register and the input buffer fill up.
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= (hold_left == 1);
        end else if (m_valid && m_ready) begin
            if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 5);
            m_ready <= (gap == 0);
            ready_gap <= gap;
        end else if (!m_ready) begin
            if (ready_gap <= 1)
                m_ready <= 1'b1;
            else
                ready_gap <= ready_gap - 1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        scfp_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.frame_ok        = m_frame_ok;
            seen.function_code   = m_function_code;
            seen.update_kind     = m_update_kind;
            seen.command_value   = m_command_value;
            seen.speed_value     = m_speed_value;
            seen.direction_value = m_direction_value;
            tracker.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[sum_checked_frame_parser_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned phase_limit [5];
        int unsigned phase_budget [5];
        tracker = new();
        phase_limit = '{1, 255, 0, 6, 0};
        phase_limit[4] = $urandom_range(1, 255);
        phase_budget = '{50, 130, 50, 130, 130};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset limit: extreme command and motion values,
        // a rejected function byte, and a zero length whose next header byte is dropped.
        push_framed(FUNC_COMMAND, 8'd1, 32'hFF00_0000, 1'b0);
        push_framed(FUNC_MOTION, 8'd4, 32'h8000_7FFF, 1'b0);
        frame_stream.push_back(HDR_BYTE);
        frame_stream.push_back(HDR_BYTE);
        frame_stream.push_back(FUNC_BOUND);
        frame_stream.push_back(HDR_BYTE);
        frame_stream.push_back(HDR_BYTE);
        frame_stream.push_back(8'hF0);
        frame_stream.push_back(8'h00);
        frame_stream.push_back(HDR_BYTE);
        send_stream();
        wait_drained();

        foreach (phase_limit[p]) begin
            program_limit(8'(phase_limit[p]));
            while (frame_stream.size() < phase_budget[p])
                push_random_traffic(8'(phase_limit[p]));
            if (phase_limit[p] == 255) want_hold <= 1'b1;
            send_stream();
            wait_drained();
        end

        if (tracker.errors == 0)
            $display("[sum_checked_frame_parser_unit] OK");
        else
            $display("[sum_checked_frame_parser_unit] ERROR");
        $finish;
    end

endmodule
